@@ sv/srcu_pkg.sv @@
`timescale 1ns / 1ps
// srcu_pkg: word types, mode codes and sprite test functions for the
// sprite redundancy classifier. No dependencies.
package srcu_pkg;

	localparam int HIST_DEPTH  = 4;
	localparam int SPRITE_BYTES = 32;
	localparam int FRAME_WORDS = 16;

	// format codes
	localparam logic [3:0] MODE_FULL       = 4'd1;
	localparam logic [3:0] MODE_HFLIP1     = 4'd2;
	localparam logic [3:0] MODE_VFLIP1     = 4'd3;
	localparam logic [3:0] MODE_HFLIP2     = 4'd4;
	localparam logic [3:0] MODE_VFLIP2     = 4'd5;
	localparam logic [3:0] MODE_VFLIP3     = 4'd6;
	localparam logic [3:0] MODE_CW1        = 4'd7;
	localparam logic [3:0] MODE_CW2        = 4'd8;
	localparam logic [3:0] MODE_CW4        = 4'd9;
	localparam logic [3:0] MODE_HVCENTER   = 4'd10;
	localparam logic [3:0] MODE_HVSYMMETRY = 4'd11;
	localparam logic [3:0] MODE_HCENTER    = 4'd12;
	localparam logic [3:0] MODE_VCENTER    = 4'd13;
	localparam logic [3:0] MODE_HSYMMETRY  = 4'd14;
	localparam logic [3:0] MODE_VSYMMETRY  = 4'd15;

	typedef logic [7:0] octet_t;
	typedef octet_t [SPRITE_BYTES-1:0] sprite_bytes_t;

	typedef struct packed {
		logic [63:0] left_upper_rows;
		logic [63:0] left_lower_rows;
		logic [63:0] right_upper_rows;
		logic [63:0] right_lower_rows;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  mode_code;
		logic [15:0] sprite_offset;
		logic [15:0] data_word;
		logic        word_valid;
		logic        last_word;
	} out_word_t;

	typedef struct packed {
		logic lr;   // left-right mirror of held sprite
		logic tb;   // top-bottom mirror of held sprite
		logic rot;  // clockwise turn of held sprite
	} cell_flags_t;

	typedef struct packed {
		logic [3:0]                   mode;
		logic [FRAME_WORDS-1:0][15:0] words;
		logic [3:0]                   last_idx;
		logic                         word_valid;
	} frame_t;

	// bytes added to the running offset per mode
	localparam logic [5:0] MODE_BYTES [16] = '{
		6'd0, 6'd32, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd0, 6'd0, 6'd8, 6'd8, 6'd16, 6'd16, 6'd16, 6'd16
	};

	// first byte of each group of eight rows read for a clockwise turn
	localparam logic [4:0] ROT_BASE [4] = '{5'd8, 5'd24, 5'd0, 5'd16};

	function automatic sprite_bytes_t unpack(input in_word_t w);
		logic [255:0] flat;
		sprite_bytes_t s;
		flat = w;
		for (int n = 0; n < SPRITE_BYTES; n++) begin
			s[n] = flat[255-8*n -: 8];
		end
		return s;
	endfunction

	function automatic octet_t rev8(input octet_t v);
		octet_t r;
		for (int b = 0; b < 8; b++) begin
			r[b] = v[7-b];
		end
		return r;
	endfunction

	function automatic logic lr_mirror(input sprite_bytes_t s, input sprite_bytes_t p);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (s[i] != rev8(p[i+16]) || s[i+16] != rev8(p[i])) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic tb_mirror(input sprite_bytes_t s, input sprite_bytes_t p);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (s[i] != p[15-i] || s[i+16] != p[31-i]) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic turned(input sprite_bytes_t s, input sprite_bytes_t p);
		logic ok;
		octet_t c;
		ok = 1'b1;
		for (int i = 0; i < SPRITE_BYTES; i++) begin
			for (int j = 0; j < 8; j++) begin
				c[j] = p[int'(ROT_BASE[i/8]) + j][7 - (i % 8)];
			end
			if (c != s[i]) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic tb_sym(input sprite_bytes_t s);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (s[i] != s[15-i] || s[i+16] != s[31-i]) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic lr_sym(input sprite_bytes_t s);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (s[i] != rev8(s[i+16])) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic rows_empty(input sprite_bytes_t s);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (s[i] != 8'h00 || s[15-i] != 8'h00 || s[i+16] != 8'h00 || s[31-i] != 8'h00)
				ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic cols_empty(input sprite_bytes_t s);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if ((s[i] & 8'hF0) != 8'h00 || (s[i+16] & 8'h0F) != 8'h00) ok = 1'b0;
		end
		return ok;
	endfunction

	// payload bytes in emit order; unused bytes are zero
	function automatic sprite_bytes_t payload(input logic [3:0] mode, input sprite_bytes_t s);
		sprite_bytes_t p;
		p = '0;
		case (mode)
			MODE_FULL: p = s;
			MODE_HVCENTER: begin
				for (int k = 0; k < 8; k++) p[k] = {s[4+k][3:0], s[20+k][7:4]};
			end
			MODE_HVSYMMETRY: begin
				for (int k = 0; k < 8; k++) p[k] = s[k];
			end
			MODE_HCENTER: begin
				for (int k = 0; k < 16; k++) p[k] = {s[k][3:0], s[k+16][7:4]};
			end
			MODE_VCENTER: begin
				for (int k = 0; k < 8; k++) begin
					p[k]   = s[4+k];
					p[k+8] = s[20+k];
				end
			end
			MODE_HSYMMETRY: begin
				for (int k = 0; k < 8; k++) begin
					p[k]   = s[k];
					p[k+8] = s[16+k];
				end
			end
			MODE_VSYMMETRY: begin
				for (int k = 0; k < 16; k++) p[k] = s[k];
			end
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

@@ sv/srcu_cell.sv @@
`timescale 1ns / 1ps
// srcu_cell: one history slot. Holds a past sprite, compares it with the
// sprite in stage 1 and hands it to the next slot on shift. Uses srcu_pkg.
module srcu_cell import srcu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  sprite_bytes_t prev_sprite,
	input  logic          prev_valid,
	input  sprite_bytes_t probe,
	output sprite_bytes_t held_sprite,
	output logic          held_valid,
	output cell_flags_t   flags
);

	sprite_bytes_t sprite_q;
	logic          valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			sprite_q <= prev_sprite;
		end
	end

	assign held_sprite = sprite_q;
	assign held_valid  = valid_q;

	// empty slot never matches
	assign flags.lr  = valid_q && lr_mirror(probe, sprite_q);
	assign flags.tb  = valid_q && tb_mirror(probe, sprite_q);
	assign flags.rot = valid_q && turned(probe, sprite_q);

endmodule

@@ sv/srcu_emitter.sv @@
`timescale 1ns / 1ps
// srcu_emitter: holds one classified sprite and sends it out one word per
// cycle while result_ready holds; keeps the running byte offset. Uses srcu_pkg.
module srcu_emitter import srcu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load_valid,
	input  frame_t    load_frame,
	output logic      load_ready,
	output logic      result_valid,
	input  logic      result_ready,
	output out_word_t result
);

	frame_t      frame_q;
	logic [15:0] offset_q;
	logic [15:0] running_q;
	logic [3:0]  idx_q;
	logic        valid_q;
	logic        is_last;
	logic        load;
	logic [16:0] next_sum;

	assign is_last    = (idx_q == frame_q.last_idx);
	assign load_ready = !valid_q || (result_ready && is_last);
	assign load       = load_valid && load_ready;
	assign next_sum   = {1'b0, running_q} + {11'd0, MODE_BYTES[load_frame.mode]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			idx_q     <= '0;
			running_q <= '0;
		end else if (load) begin
			valid_q   <= 1'b1;
			idx_q     <= '0;
			running_q <= next_sum[16] ? 16'hFFFF : next_sum[15:0];
		end else if (valid_q && result_ready) begin
			if (is_last) valid_q <= 1'b0;
			else idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q  <= load_frame;
			offset_q <= running_q;
		end
	end

	assign result_valid         = valid_q;
	assign result.mode_code     = frame_q.mode;
	assign result.sprite_offset = offset_q;
	assign result.data_word     = frame_q.words[idx_q];
	assign result.word_valid    = frame_q.word_valid;
	assign result.last_word     = is_last;

endmodule

@@ sv/sprite_redundancy_classifier_unit.sv @@
`timescale 1ns / 1ps
// sprite_redundancy_classifier_unit: top level. Stage registers, the row of
// history cells and the classifier; depends on srcu_pkg, srcu_cell, srcu_emitter.
//
// One 32-byte sprite per input word; per sprite the block emits 1 to 16
// result words carrying the format code, the sprite's byte offset and the
// payload. A sprite has as many result words as its kind needs:
// 1 for flip/rotate matches, 4 for HVcenter/HVsymmetry, 8 for the other
// centered and symmetric kinds, 16 for full. The output serializer sends
// one word per cycle while result_ready is high; input is taken every
// cycle while it keeps up. On its way to the first result word a sprite
// passes stage 1, which compares against history, stage 2, which classifies
// and builds the payload, and the emitter, which then presents words.
// History is a row of four cells, newest first; a sprite enters cell 0 when
// it leaves stage 1, so the next sprite always compares against it.
// Running offset saturates at 65535.
module sprite_redundancy_classifier_unit import srcu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sprite_valid,
	output logic      sprite_ready,
	input  in_word_t  sprite,
	output logic      result_valid,
	input  logic      result_ready,
	output out_word_t result
);

	// stage 1: sprite under test
	logic          s1_valid_q;
	sprite_bytes_t sprite_s1;
	logic          s1_adv;

	// stage 2: sprite plus history match flags
	logic          s2_valid_q;
	sprite_bytes_t sprite_s2;
	cell_flags_t [HIST_DEPTH-1:0] flags_s2;
	logic          s2_ready;

	// history cell row
	sprite_bytes_t [HIST_DEPTH:0] chain_sprite;
	logic          [HIST_DEPTH:0] chain_valid;
	cell_flags_t   [HIST_DEPTH-1:0] cell_flags;

	// classification
	logic          hc, vc, hs, vs;
	logic [3:0]    mode;
	sprite_bytes_t pay;
	frame_t        frame;
	logic          load_ready;

	assign s2_ready     = !s2_valid_q || load_ready;
	assign s1_adv       = s1_valid_q && s2_ready;
	assign sprite_ready = !s1_valid_q || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (sprite_ready) s1_valid_q <= sprite_valid;
			if (s2_ready) s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sprite_ready && sprite_valid) sprite_s1 <= unpack(sprite);
		if (s1_adv) begin
			sprite_s2 <= sprite_s1;
			flags_s2  <= cell_flags;
		end
	end

	// cell 0 takes the sprite leaving stage 1; each cell passes its own on
	assign chain_sprite[0] = sprite_s1;
	assign chain_valid[0]  = 1'b1;

	for (genvar c = 0; c < HIST_DEPTH; c++) begin : g_cell
		srcu_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.shift       (s1_adv),
			.prev_sprite (chain_sprite[c]),
			.prev_valid  (chain_valid[c]),
			.probe       (sprite_s1),
			.held_sprite (chain_sprite[c+1]),
			.held_valid  (chain_valid[c+1]),
			.flags       (cell_flags[c])
		);
	end

	// own-layout tests on the stage 2 sprite
	assign hc = cols_empty(sprite_s2);
	assign vc = rows_empty(sprite_s2);
	assign hs = tb_sym(sprite_s2);
	assign vs = lr_sym(sprite_s2);

	// priority: history matches first, then layout kinds, else full
	always_comb begin
		if      (flags_s2[0].lr)  mode = MODE_HFLIP1;
		else if (flags_s2[0].tb)  mode = MODE_VFLIP1;
		else if (flags_s2[1].lr)  mode = MODE_HFLIP2;
		else if (flags_s2[1].tb)  mode = MODE_VFLIP2;
		else if (flags_s2[2].tb)  mode = MODE_VFLIP3;
		else if (flags_s2[0].rot) mode = MODE_CW1;
		else if (flags_s2[1].rot) mode = MODE_CW2;
		else if (flags_s2[3].rot) mode = MODE_CW4;
		else if (hc && vc)        mode = MODE_HVCENTER;
		else if (hs && vs)        mode = MODE_HVSYMMETRY;
		else if (hc)              mode = MODE_HCENTER;
		else if (vc)              mode = MODE_VCENTER;
		else if (hs)              mode = MODE_HSYMMETRY;
		else if (vs)              mode = MODE_VSYMMETRY;
		else                      mode = MODE_FULL;
	end

	assign pay = payload(mode, sprite_s2);

	always_comb begin
		frame.mode = mode;
		for (int k = 0; k < FRAME_WORDS; k++) begin
			frame.words[k] = {pay[2*k], pay[2*k+1]};
		end
		case (mode)
			MODE_FULL: begin
				frame.last_idx   = 4'd15;
				frame.word_valid = 1'b1;
			end
			MODE_HVCENTER, MODE_HVSYMMETRY: begin
				frame.last_idx   = 4'd3;
				frame.word_valid = 1'b1;
			end
			MODE_HCENTER, MODE_VCENTER, MODE_HSYMMETRY, MODE_VSYMMETRY: begin
				frame.last_idx   = 4'd7;
				frame.word_valid = 1'b1;
			end
			default: begin
				// payload-free: single word, data zero
				frame.last_idx   = 4'd0;
				frame.word_valid = 1'b0;
			end
		endcase
	end

	srcu_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (s2_valid_q),
		.load_frame   (frame),
		.load_ready   (load_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ sv/srcu_checker.sv @@
`timescale 1ns / 1ps
// srcu_checker: port-level assertions on the result stream, bound to
// sprite_redundancy_classifier_unit. Uses srcu_pkg.
module srcu_checker import srcu_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_ready,
	input out_word_t result
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result_valid dropped while stalled");

	a_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result word changed while stalled");

	a_free_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.word_valid |-> result.last_word && result.data_word == 16'h0000)
		else $error("payload-free word not single or not zero");

	a_sprite_cont: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.last_word |=>
			result_valid && $stable(result.mode_code) && $stable(result.sprite_offset))
		else $error("sprite words broken up or header changed");

	a_mode_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.mode_code != 4'd0)
		else $error("mode code zero");

endmodule

bind sprite_redundancy_classifier_unit srcu_checker u_srcu_checker (.*);
